[rtl/core/rgps_pkg.sv]
// Shared types, widths and reset constants for the radial glow pixel shader.
// No dependencies.
`default_nettype none

package rgps_pkg;

   localparam int MAX_DIM = 4096;

   localparam int CFG_W    = 13;
   localparam int COORD_W  = 12;
   localparam int CH_W     = 8;
   localparam int GLOW_W   = 4;
   localparam int HALF_W   = CFG_W - 1;
   localparam int SQ_W     = 2 * HALF_W;
   localparam int DIST_W   = SQ_W + 1;
   localparam int Q_W      = DIST_W - 2;
   localparam int KQ_W     = Q_W + 3;
   localparam int D8_W     = DIST_W + 3;
   localparam int LEVELS   = 8;
   localparam int STEPS    = LEVELS - 1;
   localparam int STEP_W   = $clog2(LEVELS);

   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 3;

   localparam logic REG_IMAGE_WIDTH = 1'b0;
   localparam logic REG_GLOW_ROWS   = 1'b1;

   localparam int RST_WIDTH_I = 1024;
   localparam int RST_ROWS_I  = 736;
   localparam int RST_CX_I    = RST_WIDTH_I / 2;
   localparam int RST_CY_I    = RST_ROWS_I / 2;
   localparam int RST_Q_I     = (RST_CX_I * RST_CX_I + RST_CY_I * RST_CY_I) / 4;

   localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(RST_WIDTH_I);
   localparam logic [CFG_W-1:0] RST_ROWS   = CFG_W'(RST_ROWS_I);
   localparam logic [SQ_W-1:0]  RST_CX_SQ  = SQ_W'(RST_CX_I * RST_CX_I);
   localparam logic [SQ_W-1:0]  RST_CY_SQ  = SQ_W'(RST_CY_I * RST_CY_I);
   localparam logic [Q_W-1:0]   RST_Q      = Q_W'(RST_Q_I);

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] alpha;
   } pix_type;

   typedef struct packed {
      logic    valid;
      logic    in_range;
      pix_type pix;
   } pipe_type;

   typedef struct packed {
      logic [CFG_W-1:0]                image_width;
      logic [CFG_W-1:0]                glow_rows;
      logic [Q_W-1:0]                  q;
      logic [STEPS-1:0][KQ_W-1:0]      kq;
   } geom_type;

endpackage

`default_nettype wire

[rtl/core/rgps_csr.sv]
// Configuration registers (APB) and derived glow limit q with its multiples 1q..7q.
// Depends on rgps_pkg.
`default_nettype none

module rgps_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [rgps_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [rgps_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [rgps_pkg::CSR_DW-1:0] csr_prdata,
   output logic                             csr_pready,
   output rgps_pkg::geom_type               geom
);
   import rgps_pkg::*;

   logic [CFG_W-1:0]           width_ff, width_in;
   logic [CFG_W-1:0]           rows_ff, rows_in;
   logic [SQ_W-1:0]            cx_sq_ff, cy_sq_ff;
   logic [Q_W-1:0]             q_ff;
   logic [STEPS-1:0][KQ_W-1:0] kq_ff;
   logic [CFG_W-1:0]           wval;
   logic [HALF_W-1:0]          cx, cy;
   logic [DIST_W-1:0]          sq_sum;
   logic                       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      wval = csr_pwdata[CFG_W-1:0];
      if (wval > CFG_W'(MAX_DIM)) begin
         wval = CFG_W'(MAX_DIM);
      end
      width_in = width_ff;
      rows_in  = rows_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_IMAGE_WIDTH: width_in = wval;
            REG_GLOW_ROWS:   rows_in  = wval;
            default:         width_in = width_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_IMAGE_WIDTH: csr_prdata = CSR_DW'(width_ff);
         REG_GLOW_ROWS:   csr_prdata = CSR_DW'(rows_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign cx     = width_ff[CFG_W-1:1];
   assign cy     = rows_ff[CFG_W-1:1];
   assign sq_sum = DIST_W'(cx_sq_ff) + DIST_W'(cy_sq_ff);

   // after a write, the derived limit passes through the squares, then q_ff, then kq_ff
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RST_WIDTH;
         rows_ff  <= RST_ROWS;
         cx_sq_ff <= RST_CX_SQ;
         cy_sq_ff <= RST_CY_SQ;
         q_ff     <= RST_Q;
         for (int i = 0; i < STEPS; i++) begin
            kq_ff[i] <= KQ_W'(RST_Q) * KQ_W'(i + 1);
         end
      end else begin
         width_ff <= width_in;
         rows_ff  <= rows_in;
         cx_sq_ff <= SQ_W'(cx) * SQ_W'(cx);
         cy_sq_ff <= SQ_W'(cy) * SQ_W'(cy);
         q_ff     <= sq_sum[DIST_W-1:2];
         for (int i = 0; i < STEPS; i++) begin
            kq_ff[i] <= KQ_W'(q_ff) * KQ_W'(i + 1);
         end
      end
   end

   assign geom.image_width = width_ff;
   assign geom.glow_rows   = rows_ff;
   assign geom.q           = q_ff;
   assign geom.kq          = kq_ff;

endmodule

`default_nettype wire

[rtl/core/rgps_dist.sv]
// Distance pipeline: range check and |dx|,|dy|, then squares, then squared distance d.
// Depends on rgps_pkg.
`default_nettype none

module rgps_dist (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic [rgps_pkg::COORD_W-1:0] column,
   input  wire logic [rgps_pkg::COORD_W-1:0] row,
   input  rgps_pkg::pix_type                 pix,
   input  rgps_pkg::geom_type                geom,
   output rgps_pkg::pipe_type                out_pipe,
   output logic      [rgps_pkg::DIST_W-1:0]  out_dist
);
   import rgps_pkg::*;

   logic              v1_ff, v2_ff, v3_ff;
   logic              r1_ff, r2_ff, r3_ff;
   pix_type           p1_ff, p2_ff, p3_ff;
   logic [HALF_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_W-1:0]   dx_sq_ff, dy_sq_ff;
   logic [DIST_W-1:0] d_ff;
   logic [HALF_W-1:0] cx, cy, col_w, row_w;
   logic              r1_in;

   assign cx    = geom.image_width[CFG_W-1:1];
   assign cy    = geom.glow_rows[CFG_W-1:1];
   assign col_w = HALF_W'(column);
   assign row_w = HALF_W'(row);

   always_comb begin
      dx_in = (col_w >= cx) ? col_w - cx : cx - col_w;
      dy_in = (row_w >= cy) ? row_w - cy : cy - row_w;
      r1_in = (CFG_W'(row) < geom.glow_rows) && (CFG_W'(column) < geom.image_width);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff    <= pix;
      r1_ff    <= r1_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      p2_ff    <= p1_ff;
      r2_ff    <= r1_ff;
      dx_sq_ff <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      dy_sq_ff <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      p3_ff    <= p2_ff;
      r3_ff    <= r2_ff;
      d_ff     <= DIST_W'(dx_sq_ff) + DIST_W'(dy_sq_ff);
   end

   assign out_pipe.valid    = v3_ff;
   assign out_pipe.in_range = r3_ff;
   assign out_pipe.pix      = p3_ff;
   assign out_dist          = d_ff;

endmodule

`default_nettype wire

[rtl/core/rgps_glow.sv]
// Glow level from d against 1q..7q, then saturating blend into the output registers.
// Depends on rgps_pkg.
`default_nettype none

module rgps_glow (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  rgps_pkg::pipe_type               in_pipe,
   input  wire logic [rgps_pkg::DIST_W-1:0] in_dist,
   input  rgps_pkg::geom_type               geom,
   output logic                             out_valid,
   output logic      [rgps_pkg::CH_W-1:0]   blue_out,
   output logic      [rgps_pkg::CH_W-1:0]   green_out,
   output logic      [rgps_pkg::CH_W-1:0]   red_out,
   output logic      [rgps_pkg::CH_W-1:0]   alpha_out,
   output logic      [rgps_pkg::GLOW_W-1:0] glow_level
);
   import rgps_pkg::*;

   logic              v4_ff, v5_ff;
   pix_type           p4_ff;
   logic [GLOW_W-1:0] glow_ff, glow_in;
   logic [D8_W-1:0]   d8;
   logic [STEPS-1:0]  hit;
   logic [STEP_W-1:0] steps;
   logic [CH_W:0]     sum_b, sum_g, sum_r;
   logic [CH_W-1:0]   b_ff, g_ff, r_ff, a_ff;
   logic [GLOW_W-1:0] lvl_ff;

   always_comb begin
      d8 = {in_dist, 3'b000};
      for (int i = 0; i < STEPS; i++) begin
         hit[i] = D8_W'(geom.kq[i]) <= d8;
      end
      steps = STEP_W'($countones(hit));
      if (in_pipe.in_range && (geom.q != '0) && (in_dist < DIST_W'(geom.q))) begin
         glow_in = GLOW_W'(LEVELS) - GLOW_W'(steps);
      end else begin
         glow_in = '0;
      end
   end

   always_comb begin
      sum_b = (CH_W+1)'(p4_ff.blue)  + (CH_W+1)'(glow_ff);
      sum_g = (CH_W+1)'(p4_ff.green) + (CH_W+1)'(glow_ff >> 1);
      sum_r = (CH_W+1)'(p4_ff.red)   + (CH_W+1)'(glow_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= in_pipe.valid;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      p4_ff   <= in_pipe.pix;
      glow_ff <= glow_in;
      b_ff    <= sum_b[CH_W] ? '1 : sum_b[CH_W-1:0];
      g_ff    <= sum_g[CH_W] ? '1 : sum_g[CH_W-1:0];
      r_ff    <= sum_r[CH_W] ? '1 : sum_r[CH_W-1:0];
      a_ff    <= p4_ff.alpha;
      lvl_ff  <= glow_ff;
   end

   assign out_valid  = v5_ff;
   assign blue_out   = b_ff;
   assign green_out  = g_ff;
   assign red_out    = r_ff;
   assign alpha_out  = a_ff;
   assign glow_level = lvl_ff;

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> glow_ff <= GLOW_W'(LEVELS))
      else $error("glow level above maximum");

   a_no_glow_passthru: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && glow_ff == '0) |=>
         (b_ff == $past(p4_ff.blue) && g_ff == $past(p4_ff.green)
          && r_ff == $past(p4_ff.red)))
      else $error("pixel without glow was altered");

   a_never_darker: assert property (@(posedge clock) disable iff (reset)
      v4_ff |=> (b_ff >= $past(p4_ff.blue) && r_ff >= $past(p4_ff.red)
                 && g_ff >= $past(p4_ff.green)))
      else $error("blend reduced a channel");

endmodule

`default_nettype wire

[rtl/core/radial_glow_pixel_shader_core.sv]
// Top level of the radial glow pixel shader: APB registers, distance pipe, glow/blend pipe.
// Depends on rgps_pkg, rgps_csr, rgps_dist, rgps_glow.
//
// One pixel per clock: busy is always low, so an item is taken at every edge where
// start is high. Each item returns exactly one result on the rsp_ ports, strobed by
// rsp_strobe for one cycle, after the accepting edge and five register stages:
// range/abs-diff, squares, distance sum, level compare, saturating blend. The
// receiver cannot stall. Register writes take effect for items accepted from the edge
// after the write; the derived glow limit settles through three registered steps.
`default_nettype none

module radial_glow_pixel_shader_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [rgps_pkg::COORD_W-1:0] req_column,
   input  wire logic [rgps_pkg::COORD_W-1:0] req_row,
   input  wire logic [rgps_pkg::CH_W-1:0]    req_blue_in,
   input  wire logic [rgps_pkg::CH_W-1:0]    req_green_in,
   input  wire logic [rgps_pkg::CH_W-1:0]    req_red_in,
   input  wire logic [rgps_pkg::CH_W-1:0]    req_alpha_in,
   output logic                              rsp_strobe,
   output logic      [rgps_pkg::CH_W-1:0]    rsp_blue_out,
   output logic      [rgps_pkg::CH_W-1:0]    rsp_green_out,
   output logic      [rgps_pkg::CH_W-1:0]    rsp_red_out,
   output logic      [rgps_pkg::CH_W-1:0]    rsp_alpha_out,
   output logic      [rgps_pkg::GLOW_W-1:0]  rsp_glow_level,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [rgps_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [rgps_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [rgps_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import rgps_pkg::*;

   geom_type          geom;
   pix_type           pix;
   pipe_type          dist_pipe;
   logic [DIST_W-1:0] dist_sq;
   logic              accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign pix.blue  = req_blue_in;
   assign pix.green = req_green_in;
   assign pix.red   = req_red_in;
   assign pix.alpha = req_alpha_in;

   rgps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .geom        (geom)
   );

   rgps_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .column   (req_column),
      .row      (req_row),
      .pix      (pix),
      .geom     (geom),
      .out_pipe (dist_pipe),
      .out_dist (dist_sq)
   );

   rgps_glow u_glow (
      .clock      (clock),
      .reset      (reset),
      .in_pipe    (dist_pipe),
      .in_dist    (dist_sq),
      .geom       (geom),
      .out_valid  (rsp_strobe),
      .blue_out   (rsp_blue_out),
      .green_out  (rsp_green_out),
      .red_out    (rsp_red_out),
      .alpha_out  (rsp_alpha_out),
      .glow_level (rsp_glow_level)
   );

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_strobe)
      else $error("accepted item produced no result");

   a_alpha_kept: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 (rsp_alpha_out == $past(req_alpha_in, 5)))
      else $error("alpha changed in flight");

   a_glow_green: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_glow_level == '0) |-> rsp_blue_out == $past(req_blue_in, 5))
      else $error("unglowed blue changed");

endmodule

`default_nettype wire

[dv/tb_radial_glow_pixel_shader_core.sv]
// Self-checking testbench for radial_glow_pixel_shader_core: drives pixels and APB writes,
// predicts every shaded item and compares it field by field. Depends on rgps_pkg and the RTL.
`default_nettype none

module tb_radial_glow_pixel_shader_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rgps_pkg::*;

   localparam int CHAN_MAX   = 255;
   localparam int SETTLE     = 10;
   localparam int MAX_REPORT = 10;
   localparam int LIMIT      = 400000;

   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic [CH_W-1:0]    blue;
      logic [CH_W-1:0]    green;
      logic [CH_W-1:0]    red;
      logic [CH_W-1:0]    alpha;
   } pixel_req_type;

   typedef struct packed {
      logic [CH_W-1:0]   blue;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   alpha;
      logic [GLOW_W-1:0] glow;
   } shaded_pix_type;

   logic                clock;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic                busy;
   logic [COORD_W-1:0]  req_column  = '0;
   logic [COORD_W-1:0]  req_row     = '0;
   logic [CH_W-1:0]     req_blue_in = '0;
   logic [CH_W-1:0]     req_green_in = '0;
   logic [CH_W-1:0]     req_red_in  = '0;
   logic [CH_W-1:0]     req_alpha_in = '0;
   logic                rsp_strobe;
   logic [CH_W-1:0]     rsp_blue_out;
   logic [CH_W-1:0]     rsp_green_out;
   logic [CH_W-1:0]     rsp_red_out;
   logic [CH_W-1:0]     rsp_alpha_out;
   logic [GLOW_W-1:0]   rsp_glow_level;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   pixel_req_type  pixel_queue[$];
   shaded_pix_type shaded_queue[$];
   int          cfg_width   = RST_WIDTH_I;
   int          cfg_rows    = RST_ROWS_I;
   int          glow_radius = 0;
   int          mismatches  = 0;
   int          gap_left    = 0;
   bit          idle_en     = 1'b1;
   int          cycle_count = 0;

   radial_glow_pixel_shader_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_column     (req_column),
      .req_row        (req_row),
      .req_blue_in    (req_blue_in),
      .req_green_in   (req_green_in),
      .req_red_in     (req_red_in),
      .req_alpha_in   (req_alpha_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_red_out    (rsp_red_out),
      .rsp_alpha_out  (rsp_alpha_out),
      .rsp_glow_level (rsp_glow_level),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [CH_W-1:0] sat_add(logic [CH_W-1:0] chan, int amount);
      int sum;
      sum = int'(chan) + amount;
      return (sum > CHAN_MAX) ? CH_W'(CHAN_MAX) : CH_W'(sum);
   endfunction

   function automatic shaded_pix_type glow_shade(pixel_req_type px);
      shaded_pix_type res;
      longint      cx, cy, q, dx, dy, dsq;
      int          lvl;
      lvl = 0;
      if (int'(px.row) < cfg_rows && int'(px.column) < cfg_width) begin
         cx   = cfg_width / 2;
         cy   = cfg_rows / 2;
         q    = (cx * cx + cy * cy) / 4;
         dx   = longint'(px.column) - cx;
         dy   = longint'(px.row) - cy;
         dsq  = dx * dx + dy * dy;
         if (q != 0 && dsq < q)
            lvl = LEVELS - int'((dsq * LEVELS) / q);
      end
      res.blue  = sat_add(px.blue, lvl);
      res.green = sat_add(px.green, lvl / 2);
      res.red   = sat_add(px.red, lvl);
      res.alpha = px.alpha;
      res.glow  = GLOW_W'(lvl);
      return res;
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORT)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // sender: one item per cycle unless in an idle burst
   always @(negedge clock) begin : drive
      logic go;
      go = 1'b0;
      if (!reset && pixel_queue.size() > 0) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (idle_en && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 16) - 1;
         end else begin
            go = 1'b1;
         end
      end
      start <= go;
      if (go) begin
         req_column   <= pixel_queue[0].column;
         req_row      <= pixel_queue[0].row;
         req_blue_in  <= pixel_queue[0].blue;
         req_green_in <= pixel_queue[0].green;
         req_red_in   <= pixel_queue[0].red;
         req_alpha_in <= pixel_queue[0].alpha;
      end
   end

   always @(posedge clock) begin : accept
      pixel_req_type px;
      if (!reset && start && !busy && pixel_queue.size() > 0) begin
         px = '{req_column, req_row, req_blue_in, req_green_in, req_red_in, req_alpha_in};
         shaded_queue.push_back(glow_shade(px));
         void'(pixel_queue.pop_front());
      end
   end

   always @(posedge clock) begin : monitor
      shaded_pix_type want;
      shaded_pix_type got;
      if (!reset && rsp_strobe) begin
         got = '{rsp_blue_out, rsp_green_out, rsp_red_out, rsp_alpha_out, rsp_glow_level};
         if (shaded_queue.size() == 0) begin
            note_mismatch($sformatf("unexpected item b=%0d g=%0d r=%0d a=%0d glow=%0d",
                                    got.blue, got.green, got.red, got.alpha, got.glow));
         end else begin
            want = shaded_queue.pop_front();
            if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
                got.alpha !== want.alpha || got.glow !== want.glow)
               note_mismatch($sformatf(
                  "exp b=%0d g=%0d r=%0d a=%0d glow=%0d, got b=%0d g=%0d r=%0d a=%0d glow=%0d",
                  want.blue, want.green, want.red, want.alpha, want.glow,
                  got.blue, got.green, got.red, got.alpha, got.glow));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic csr_write(input logic idx, input logic [CSR_DW-1:0] value);
      int v;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      v = int'(value[CFG_W-1:0]);
      if (v > MAX_DIM)
         v = MAX_DIM;
      if (idx == REG_IMAGE_WIDTH)
         cfg_width = v;
      else
         cfg_rows = v;
   endtask

   task automatic csr_expect(input logic idx, input int want);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DW'(want))
         note_mismatch($sformatf("register %0d read %0d, exp %0d", idx, csr_prdata, want));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain();
      while (pixel_queue.size() != 0 || shaded_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DW-1:0] width_raw, input logic [CSR_DW-1:0] rows_raw);
      longint q;
      drain();
      csr_write(REG_IMAGE_WIDTH, width_raw);
      csr_write(REG_GLOW_ROWS, rows_raw);
      csr_expect(REG_IMAGE_WIDTH, cfg_width);
      csr_expect(REG_GLOW_ROWS, cfg_rows);
      q = (longint'(cfg_width / 2) * (cfg_width / 2) + longint'(cfg_rows / 2) * (cfg_rows / 2)) / 4;
      glow_radius = 0;
      while (longint'(glow_radius + 1) * (glow_radius + 1) <= q)
         glow_radius++;
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic int near_coord(int center);
      int c;
      c = center + $urandom_range(0, 2 * glow_radius + 2) - glow_radius - 1;
      if (c < 0)
         c = 0;
      if (c > (1 << COORD_W) - 1)
         c = (1 << COORD_W) - 1;
      return c;
   endfunction

   function automatic logic [CH_W-1:0] pick_chan();
      return ($urandom_range(0, 3) == 0) ? CH_W'($urandom_range(240, CHAN_MAX))
                                         : CH_W'($urandom_range(0, CHAN_MAX));
   endfunction

   task automatic add_pixel(input int col, input int row, input int b, input int g,
                            input int r, input int a);
      pixel_queue.push_back('{COORD_W'(col), COORD_W'(row), CH_W'(b), CH_W'(g), CH_W'(r),
                              CH_W'(a)});
   endtask

   task automatic shoot(input int n);
      pixel_req_type px;
      repeat (n) begin
         if ($urandom_range(0, 9) < 6) begin
            px.column = COORD_W'(near_coord(cfg_width / 2));
            px.row    = COORD_W'(near_coord(cfg_rows / 2));
         end else begin
            px.column = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
            px.row    = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
         end
         px.blue  = pick_chan();
         px.green = pick_chan();
         px.red   = pick_chan();
         px.alpha = CH_W'($urandom_range(0, CHAN_MAX));
         pixel_queue.push_back(px);
      end
      drain();
   endtask

   task automatic random_config();
      int w, h;
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, MAX_DIM);
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, MAX_DIM);
      configure(w, h);
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_expect(REG_IMAGE_WIDTH, RST_WIDTH_I);
      csr_expect(REG_GLOW_ROWS, RST_ROWS_I);
      configure(RST_WIDTH_I, RST_ROWS_I);

      // reset geometry: center (512,368), radius about 315
      add_pixel(512, 368, 0, 0, 0, 0);
      add_pixel(512, 368, 255, 255, 255, 255);
      add_pixel(512, 368, 250, 251, 249, 7);
      add_pixel(632, 368, 100, 100, 100, 1);
      add_pixel(827, 368, 10, 20, 30, 40);
      add_pixel(828, 368, 10, 20, 30, 40);
      add_pixel(197, 368, 254, 254, 254, 128);
      add_pixel(512, 468, 0, 255, 0, 255);
      add_pixel(0, 0, 0, 0, 0, 0);
      add_pixel(4095, 4095, 255, 255, 255, 255);
      add_pixel(1023, 368, 1, 2, 3, 4);
      add_pixel(1024, 368, 1, 2, 3, 4);
      add_pixel(512, 735, 5, 6, 7, 8);
      add_pixel(512, 736, 5, 6, 7, 8);
      add_pixel(600, 400, 254, 255, 253, 128);
      add_pixel(520, 370, 8'hAA, 8'h55, 8'hAA, 8'h55);
      add_pixel(512, 53, 8'h55, 8'hAA, 8'h55, 8'hAA);
      shoot(300);

      configure(1, 1);                          // zero limit
      shoot(100);
      configure(MAX_DIM, MAX_DIM);
      shoot(250);
      configure(0, RST_ROWS_I);                 // zero width
      shoot(80);
      configure(RST_WIDTH_I, 0);                // zero rows
      shoot(80);
      configure(8191, 5000);                    // oversized, saturates
      shoot(150);
      configure(32'hFFFF_FFFF, 32'h0001_2000);  // upper bits dropped
      shoot(60);
      configure(640, 480);
      shoot(250);
      repeat (3) begin
         random_config();
         shoot(150);
      end
      configure(3, 5);                          // only the center pixel glows
      add_pixel(1, 2, 255, 254, 0, 9);
      add_pixel(0, 2, 255, 254, 0, 9);
      add_pixel(1, 1, 255, 254, 0, 9);
      shoot(50);

      // tail without idling
      configure(800, 600);
      idle_en = 1'b0;
      shoot(160);

      if (mismatches == 0 && shaded_queue.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

[radial_glow_pixel_shader_core.f]
rtl/core/rgps_pkg.sv
rtl/core/rgps_csr.sv
rtl/core/rgps_dist.sv
rtl/core/rgps_glow.sv
rtl/core/radial_glow_pixel_shader_core.sv
dv/tb_radial_glow_pixel_shader_core.sv
